// File: sv/assert_macros.svh
// Assertion macros shared by the grid ray caster modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("grid ray caster check failed");

// Checks that an antecedent is followed by a consequent in the next cycle.
`define GRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid ray caster sequence check failed");

`endif

// File: sv/grc_pkg.sv
// Shared types and constants of the grid ray caster.
package grc_pkg;

   localparam int MAP_WIDTH  = 16;
   localparam int MAP_HEIGHT = 16;
   localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int MX_W       = $clog2(MAP_WIDTH);
   localparam int MY_W       = $clog2(MAP_HEIGHT);

   localparam int DIV_NUM_W  = 36;
   localparam int DIV_DEN_W  = 24;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

   localparam logic [19:0] DIST_MAX = 20'hFFFFF;
   localparam logic [12:0] ONE_CELL = 13'd4096;

   typedef enum logic {
      CSR_SCREEN_HEIGHT = 1'b0,
      CSR_MAX_STEPS     = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_RAY  = 1'b1
   } kind_type;

   typedef struct packed {
      logic                  en;
      logic [CELL_AW-1:0]    addr;
      logic [1:0]            data;
   } map_wr_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_NUM_W-1:0]  dividend;
      logic [DIV_DEN_W-1:0]  divisor;
   } div_req_type;

endpackage

// File: sv/grc_map.sv
// Wall map store with registered read and per-cell valid bits.
module grc_map (
   input  logic                       clock,
   input  logic                       reset,
   input  grc_pkg::map_wr_type        wr,
   input  logic [grc_pkg::CELL_AW-1:0] rd_addr,
   output logic [1:0]                 rd_data
);
   import grc_pkg::*;

   logic [1:0]            mem [CELL_COUNT];
   logic [CELL_COUNT-1:0] valid_ff;
   logic [1:0]            rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 2'd0;
   end

   // A cell never written since reset reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/grc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module grc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  grc_pkg::div_req_type          req,
   output logic                          done,
   output logic [grc_pkg::DIV_NUM_W-1:0] quotient
);
   import grc_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `GRC_ASSERT_NEXT(a_start_busy, clock, reset, req.start, busy_ff)
   `GRC_ASSERT(a_done_idle, clock, reset, done_ff |-> !busy_ff)
   `GRC_ASSERT(a_cnt_range, clock, reset, cnt_ff <= DIV_CNT_W'(DIV_NUM_W))

endmodule

// File: sv/grid_ray_caster_top.sv
// Top level of the grid ray caster: sequencer, walk datapath and result register.
//
// Input channel req_: one transfer is either a map load (req_tuser = 0) or a ray (1).
// A load writes one cell of the 16x16 wall map in the cycle it is taken and gives
// no result. A ray walks the map by grid DDA and gives one result on rsp_.
// csr_ writes screen_height (index 0) or max_steps (index 1) at any edge with
// csr_we high; the user must make writes only while the block is idle (not enforced).
// Ray sequence: setup multiplies (ST_MULX, ST_MULY), then per grid step a compare and
// update (ST_STEP) and a registered map read (ST_CHECK), then, where needed, the distance
// division and the line height division, both on the one shared restoring divider
// (one quotient bit a cycle), and last the output register; req_tready is low meanwhile.
// The result register holds a finished result while the receiver stalls; the
// block takes the next transfer and stalls only when a second result is ready.
// Reset (synchronous) clears the map to empty, sets screen_height to 60 and
// max_steps to 50 and drops rsp_tvalid.
`include "assert_macros.svh"
module grid_ray_caster_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind
   input  logic [0:0]  req_tuser,
   // cell_index, cell_value, pos_x, pos_y, ray_dir_x, ray_dir_y, zero fill
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hit, side, wall_value, hit_x, hit_y, wall_distance, line_height
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);
   import grc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MULX, ST_MULY, ST_STEP, ST_CHECK, ST_FIN,
      ST_DIVD, ST_MULL, ST_LSTART, ST_DIVL, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  sh_ff, mxs_ff;
   logic [8:0]  limit;

   logic [7:0]          in_cell_index;
   logic [1:0]          in_cell_value;
   logic [15:0]         in_pos_x, in_pos_y;
   logic signed [15:0]  in_dir_x, in_dir_y;

   logic [15:0] adx_ff, adx_in, ady_ff, ady_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic [20:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [36:0] px_ff, px_in, py_ff, py_in;
   logic [MX_W:0] mx_ff, mx_in;
   logic [MY_W:0] my_ff, my_in;
   logic [8:0]  steps_ff, steps_in;
   logic        side_ff, side_in;
   logic        hit_ff, hit_in;
   logic [1:0]  wall_ff, wall_in;
   logic [19:0] dist_ff, dist_in;
   logic [7:0]  line_ff, line_in;
   logic [23:0] prod_ff, prod_in;

   logic        rv_ff, rv_in;
   logic [39:0] rd_ff, rd_in;

   logic [31:0] mul_p;
   logic [15:0] mul_a, mul_b;
   logic [20:0] num;
   logic [15:0] ad;
   logic        out_map;

   map_wr_type  map_wr;
   logic [1:0]  map_rd;
   div_req_type div_req;
   logic        div_done;
   logic [DIV_NUM_W-1:0] div_q;

   assign in_cell_index = req_tdata[7:0];
   assign in_cell_value = req_tdata[9:8];
   assign in_pos_x      = req_tdata[25:10];
   assign in_pos_y      = req_tdata[41:26];
   assign in_dir_x      = req_tdata[57:42];
   assign in_dir_y      = req_tdata[73:58];

   assign req_tready = (state_ff == ST_IDLE);
   assign limit      = {1'b0, mxs_ff} + 9'd2;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff  <= 8'd60;
         mxs_ff <= 8'd50;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SCREEN_HEIGHT: sh_ff  <= csr_wdata;
            CSR_MAX_STEPS:     mxs_ff <= csr_wdata;
            default:           sh_ff  <= sh_ff;
         endcase
      end
   end

   assign map_wr.en   = req_tvalid && req_tready && (req_tuser[0] == KIND_LOAD);
   assign map_wr.addr = in_cell_index;
   assign map_wr.data = in_cell_value;

   // The cell entered by a step is read at the same edge, so the check cycle sees it.
   grc_map u_map (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_addr ({my_in[MY_W-1:0], mx_in[MX_W-1:0]}),
      .rd_data (map_rd)
   );

   grc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   // One shared multiplier: setup products and the line height numerator.
   always_comb begin
      case (state_ff)
         ST_MULX: begin mul_a = nx_ff[15:0]; mul_b = ady_ff; end
         ST_MULY: begin mul_a = ny_ff[15:0]; mul_b = adx_ff; end
         default: begin mul_a = {8'd0, sh_ff}; mul_b = ad; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign ad      = side_ff ? ady_ff : adx_ff;
   assign num     = (side_ff ? ny_ff : nx_ff) - 21'(ONE_CELL);
   assign out_map = mx_ff[MX_W] || my_ff[MY_W];

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {1'b0, num, 14'd0};
      div_req.divisor  = {8'd0, ad};
      if (state_ff == ST_LSTART) begin
         div_req.dividend = {12'd0, prod_ff};
         div_req.divisor  = {1'b0, num, 2'b00};
         div_req.start    = 1'b1;
      end else if (state_ff == ST_FIN && ad != 16'd0 && num != 21'd0
                   && {1'b0, num} < {ad, 6'd0}) begin
         div_req.start = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      adx_in = adx_ff; ady_in = ady_ff; sx_in = sx_ff; sy_in = sy_ff;
      nx_in = nx_ff; ny_in = ny_ff; px_in = px_ff; py_in = py_ff;
      mx_in = mx_ff; my_in = my_ff; steps_in = steps_ff; side_in = side_ff;
      hit_in = hit_ff; wall_in = wall_ff; dist_in = dist_ff; line_in = line_ff;
      prod_in = prod_ff; rv_in = rv_ff; rd_in = rd_ff;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tuser[0] == KIND_RAY) begin
               sx_in    = in_dir_x[15];
               sy_in    = in_dir_y[15];
               adx_in   = in_dir_x[15] ? 16'(~in_dir_x + 16'sd1) : in_dir_x;
               ady_in   = in_dir_y[15] ? 16'(~in_dir_y + 16'sd1) : in_dir_y;
               nx_in    = in_dir_x[15] ? {9'd0, in_pos_x[11:0]}
                                       : 21'(ONE_CELL - {1'b0, in_pos_x[11:0]});
               ny_in    = in_dir_y[15] ? {9'd0, in_pos_y[11:0]}
                                       : 21'(ONE_CELL - {1'b0, in_pos_y[11:0]});
               mx_in    = {1'b0, in_pos_x[15:12]};
               my_in    = {1'b0, in_pos_y[15:12]};
               steps_in = '0;
               hit_in   = 1'b0;
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            px_in    = {5'd0, mul_p};
            state_in = ST_MULY;
         end
         ST_MULY: begin
            py_in    = {5'd0, mul_p};
            state_in = ST_STEP;
         end
         ST_STEP: begin
            // Cross the grid line that the ray meets first.
            if (px_ff < py_ff) begin
               nx_in   = nx_ff + 21'(ONE_CELL);
               px_in   = px_ff + {9'd0, ady_ff, 12'd0};
               mx_in   = sx_ff ? mx_ff - 1'b1 : mx_ff + 1'b1;
               side_in = 1'b0;
            end else begin
               ny_in   = ny_ff + 21'(ONE_CELL);
               py_in   = py_ff + {9'd0, adx_ff, 12'd0};
               my_in   = sy_ff ? my_ff - 1'b1 : my_ff + 1'b1;
               side_in = 1'b1;
            end
            steps_in = steps_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (out_map) begin
               state_in = ST_FIN;
            end else if (map_rd != 2'd0) begin
               hit_in   = 1'b1;
               state_in = ST_FIN;
            end else if (steps_ff >= limit) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_STEP;
            end
            wall_in = out_map ? 2'd0 : map_rd;
         end
         ST_FIN: begin
            if (ad == 16'd0) begin
               dist_in  = DIST_MAX;
               line_in  = 8'd0;
               state_in = ST_DONE;
            end else if (num == 21'd0) begin
               dist_in  = '0;
               line_in  = sh_ff;
               state_in = ST_DONE;
            end else if (div_req.start) begin
               state_in = ST_DIVD;
            end else begin
               dist_in  = DIST_MAX;
               state_in = ST_MULL;
            end
         end
         ST_DIVD: begin
            if (div_done) begin
               dist_in  = div_q[19:0];
               state_in = ST_MULL;
            end
         end
         ST_MULL: begin
            prod_in  = mul_p[23:0];
            state_in = ST_LSTART;
         end
         ST_LSTART: begin
            state_in = ST_DIVL;
         end
         ST_DIVL: begin
            if (div_done) begin
               line_in  = (div_q > {28'd0, sh_ff}) ? sh_ff : div_q[7:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rd_in    = {line_ff, dist_ff, my_ff[MY_W-1:0], mx_ff[MX_W-1:0],
                           hit_ff ? wall_ff : 2'd0, side_ff, hit_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         steps_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         steps_ff <= steps_in;
         hit_ff   <= hit_in;
      end
      adx_ff <= adx_in; ady_ff <= ady_in; sx_ff <= sx_in; sy_ff <= sy_in;
      nx_ff <= nx_in; ny_ff <= ny_in; px_ff <= px_in; py_ff <= py_in;
      mx_ff <= mx_in; my_ff <= my_in; side_ff <= side_in; wall_ff <= wall_in;
      dist_ff <= dist_in; line_ff <= line_in; prod_ff <= prod_in; rd_ff <= rd_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   `GRC_ASSERT(a_steps_limit, clock, reset, (state_ff == ST_STEP) |-> (steps_ff < limit))
   `GRC_ASSERT(a_hit_wall, clock, reset, rv_ff |-> (rd_ff[0] == (rd_ff[3:2] != 2'd0)))
   `GRC_ASSERT(a_line_cap, clock, reset, rv_ff |-> (rd_ff[39:32] <= sh_ff))

endmodule
